// File: design/srdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdf_pkg
// Shared types, constants and reset values for the signed radix digit
// formatter.
// ----------------------------------------------------------------------------
package srdf_pkg;

    // default parameter values
    localparam int DEF_MAX_SYMBOLS = 56;
    localparam int DEF_NUMBER_BITS = 32;

    // register file layout
    localparam int BASE_W     = 6;   // base_length register width
    localparam int SYM_REG_W  = 64;  // one symbol register, eight bytes
    localparam int CFG_IDX_W  = 3;   // eight registers in the map
    localparam int CFG_DATA_W = 64;
    localparam int CHAR_W     = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_BASE = 3'd1;

    // reset values: radix ten with symbols "0123456789"
    localparam logic [BASE_W-1:0]    RST_BASE_LENGTH = 6'd10;
    localparam logic [SYM_REG_W-1:0] RST_SYMBOLS_0   = 64'h3736_3534_3332_3130;
    localparam logic [SYM_REG_W-1:0] RST_SYMBOLS_1   = 64'h0000_0000_0000_3938;

    // characters
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [BASE_W-1:0] MIN_RADIX = 6'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_INVALID,
        ST_SIGN,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    // reset value of symbol register k
    function automatic logic [SYM_REG_W-1:0] sym_reset(input int k);
        logic [SYM_REG_W-1:0] val;
        val = '0;
        if (k == 0) begin
            val = RST_SYMBOLS_0;
        end else if (k == 1) begin
            val = RST_SYMBOLS_1;
        end
        return val;
    endfunction

endpackage

// File: design/signed_radix_digit_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_digit_formatter
// Formats a signed number as text in a configurable radix, most significant
// digit first, with a leading minus for negatives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one signed number a beat.
//   Output channel (o_out_valid / i_out_ready) gives one text byte a beat,
//   o_last marking the final byte of a number. A bad symbol set gives a
//   single beat with o_base_invalid and o_last set and a zero byte.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index at
//   once (0 = base_length, 1..7 = symbol bytes); write only while idle.
// Timing:
//   One number at a time; o_in_ready is low until its last beat has been
//   loaded into the output register. The symbol set is checked one symbol a
//   cycle, then a negative number's sign beat waits for a free output register,
//   and each digit is formed on one shared restoring divider, one quotient bit
//   a cycle. Digits then leave one a cycle while the output register is free.
// Reset: returns to idle with radix ten and symbols "0123456789".
// Stalls: the output register holds its beat while i_out_ready is low and
//   the sequencer waits before loading the next beat.
// ----------------------------------------------------------------------------
module signed_radix_digit_formatter #(
    parameter int MAX_SYMBOLS = srdf_pkg::DEF_MAX_SYMBOLS,
    parameter int NUMBER_BITS = srdf_pkg::DEF_NUMBER_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [srdf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srdf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [NUMBER_BITS-1:0]    i_number,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [srdf_pkg::CHAR_W-1:0]      o_out_char,
    output logic                             o_last,
    output logic                             o_base_invalid
);
    import srdf_pkg::*;

    localparam int NUM_SYM_REGS = (MAX_SYMBOLS + 7) / 8;
    localparam int IDX_W        = $clog2(MAX_SYMBOLS);
    localparam int BIT_W        = $clog2(NUMBER_BITS);
    localparam int ND_W         = $clog2(NUMBER_BITS + 1);

    // configuration registers
    logic [BASE_W-1:0]    r_base_len;
    logic [SYM_REG_W-1:0] r_sym_reg [NUM_SYM_REGS];

    // sequencer and datapath registers
    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_neg, n_neg;
    logic [NUMBER_BITS-1:0] r_mag, n_mag;
    logic [BASE_W-1:0]    r_rem, n_rem;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [IDX_W-1:0]     r_stack [NUMBER_BITS];
    logic [IDX_W-1:0]     n_stack [NUMBER_BITS];
    logic [ND_W-1:0]      r_nd, n_nd;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;
    logic                 r_out_inv, n_out_inv;

    // combinational helpers
    logic [CHAR_W-1:0]    w_sym [MAX_SYMBOLS];
    logic [IDX_W-1:0]     w_rd_addr;
    logic [CHAR_W-1:0]    w_rd_sym;
    logic                 w_dup;
    logic                 w_len_bad;
    logic                 w_sym_bad;
    logic                 w_out_free;
    logic [BASE_W:0]      w_rem_sh;
    logic                 w_ge;
    logic [BASE_W:0]      w_rem_nx;
    logic [NUMBER_BITS-1:0] w_mag_nx;

    // configuration writes, indexes beyond the stored registers are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_len <= RST_BASE_LENGTH;
            for (int k = 0; k < NUM_SYM_REGS; k++) begin
                r_sym_reg[k] <= sym_reset(k);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BASE_LENGTH) begin
                r_base_len <= i_cfg_data[BASE_W-1:0];
            end
            for (int k = 0; k < NUM_SYM_REGS; k++) begin
                if (i_cfg_index == CFG_SYMBOLS_BASE + CFG_IDX_W'(k)) begin
                    r_sym_reg[k] <= i_cfg_data[SYM_REG_W-1:0];
                end
            end
        end
    end

    // flat byte view of the symbol registers
    always_comb begin
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            w_sym[k] = r_sym_reg[k / 8][(k % 8) * 8 +: 8];
        end
    end

    // single symbol read port: checker index, or top of the digit stack
    assign w_rd_addr = (r_state == ST_EMIT) ? r_stack[0] : r_idx;
    assign w_rd_sym  = w_sym[w_rd_addr];

    // current symbol against every later symbol in the set
    always_comb begin
        w_dup = 1'b0;
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if ((BASE_W'(j) > BASE_W'(r_idx)) && (BASE_W'(j) < r_base_len)
                    && (w_sym[j] == w_rd_sym)) begin
                w_dup = 1'b1;
            end
        end
    end

    assign w_len_bad = (r_base_len < MIN_RADIX) || (r_base_len > BASE_W'(MAX_SYMBOLS));
    assign w_sym_bad = (w_rd_sym == CHAR_NUL) || (w_rd_sym == CHAR_PLUS)
                       || (w_rd_sym == CHAR_MINUS) || w_dup;

    // one restoring division step
    assign w_rem_sh = {r_rem, r_mag[NUMBER_BITS-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_base_len});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_base_len}) : w_rem_sh;
    assign w_mag_nx = {r_mag[NUMBER_BITS-2:0], w_ge};

    assign w_out_free = !r_out_valid || i_out_ready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_stack     = r_stack;
        n_nd        = r_nd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_inv   = r_out_inv;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_neg   = i_number[NUMBER_BITS-1];
                    n_mag   = i_number[NUMBER_BITS-1] ? (~i_number + 1'b1) : i_number;
                    n_idx   = '0;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_nd    = '0;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_len_bad || w_sym_bad) begin
                    n_state = ST_INVALID;
                end else if (BASE_W'(r_idx) == r_base_len - 1'b1) begin
                    n_state = r_neg ? ST_SIGN : ST_DIVIDE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_INVALID: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_NUL;
                    n_out_last  = 1'b1;
                    n_out_inv   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_out_inv   = 1'b0;
                    n_state     = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                n_mag = w_mag_nx;
                n_rem = w_rem_nx[BASE_W-1:0];
                n_bit = r_bit + 1'b1;
                if (r_bit == BIT_W'(NUMBER_BITS - 1)) begin
                    // digit done: push remainder, restart on the quotient
                    for (int k = NUMBER_BITS - 1; k > 0; k--) begin
                        n_stack[k] = r_stack[k-1];
                    end
                    n_stack[0] = w_rem_nx[IDX_W-1:0];
                    n_nd       = r_nd + 1'b1;
                    n_rem      = '0;
                    n_bit      = '0;
                    if (w_mag_nx == '0) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = w_rd_sym;
                    n_out_last  = (r_nd == ND_W'(1));
                    n_out_inv   = 1'b0;
                    for (int k = 0; k < NUMBER_BITS - 1; k++) begin
                        n_stack[k] = r_stack[k+1];
                    end
                    n_nd = r_nd - 1'b1;
                    if (r_nd == ND_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath and payload
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_stack    <= n_stack;
        r_nd       <= n_nd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_inv  <= n_out_inv;
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_last         = r_out_last;
    assign o_base_invalid = r_out_inv;

endmodule
